FILE: hdl/strided_tensor_offset_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the strided tensor offset generator.
// Each macro expands to a concurrent assertion, or to nothing for synthesis.
// ---------------------------------------------------------------------------
`ifndef STRIDED_TENSOR_OFFSET_ASSERT_SVH
`define STRIDED_TENSOR_OFFSET_ASSERT_SVH

`ifndef SYNTHESIS
`define STO_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define STO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define STO_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define STO_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: hdl/sto_pkg.sv
// ---------------------------------------------------------------------------
// Strided tensor offset package
// Widths, register indexes and defaults shared by the offset generator.
// ---------------------------------------------------------------------------
package sto_pkg;

    localparam int REG_DIMS      = 4;
    localparam int DEF_MAX_RANK  = 4;
    localparam int INDEX_W       = 32;
    localparam int SIZE_W        = 16;
    localparam int STEP_W        = 32;
    localparam int OFFSET_W      = 50;
    localparam int PROD_W        = SIZE_W + STEP_W;
    localparam int CFG_INDEX_W   = 4;
    localparam int CFG_DATA_W    = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SIZE_OUTER  = 4'd0,
        REG_SIZE_SECOND = 4'd1,
        REG_SIZE_THIRD  = 4'd2,
        REG_SIZE_INNER  = 4'd3,
        REG_STEP_OUTER  = 4'd4,
        REG_STEP_SECOND = 4'd5,
        REG_STEP_THIRD  = 4'd6,
        REG_STEP_INNER  = 4'd7
    } cfg_reg_t;

endpackage

FILE: hdl/sto_dim.sv
// ---------------------------------------------------------------------------
// Strided tensor offset, one dimension
// Pipelined restoring divider, one quotient bit per stage, followed by a
// stride multiply stage and an accumulate stage.
// ---------------------------------------------------------------------------
module sto_dim
    import sto_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic [SIZE_W-1:0]   size,
    input  logic [STEP_W-1:0]   step,
    input  logic                valid,
    input  logic [INDEX_W-1:0]  index,
    input  logic [OFFSET_W-1:0] acc,
    output logic                quot_valid,
    output logic [INDEX_W-1:0]  quot,
    output logic [OFFSET_W-1:0] quot_acc
);

    logic [SIZE_W-1:0]   divisor;

    logic                v_reg   [0:INDEX_W-1];
    logic [INDEX_W-1:0]  num_reg [0:INDEX_W-1];
    logic [SIZE_W-1:0]   rem_reg [0:INDEX_W-1];
    logic [OFFSET_W-1:0] acc_reg [0:INDEX_W-1];

    logic                v_next   [0:INDEX_W-1];
    logic [INDEX_W-1:0]  num_next [0:INDEX_W-1];
    logic [SIZE_W-1:0]   rem_next [0:INDEX_W-1];
    logic [OFFSET_W-1:0] acc_next [0:INDEX_W-1];

    logic                mul_valid_reg;
    logic [INDEX_W-1:0]  mul_quot_reg;
    logic [PROD_W-1:0]   mul_prod_reg;
    logic [OFFSET_W-1:0] mul_acc_reg;

    logic                sum_valid_reg;
    logic [INDEX_W-1:0]  sum_quot_reg;
    logic [OFFSET_W-1:0] sum_acc_reg;

    assign divisor = (size == '0) ? SIZE_W'(1) : size;

    always_comb
    begin
        logic                vin;
        logic [INDEX_W-1:0]  nin;
        logic [SIZE_W-1:0]   rin;
        logic [OFFSET_W-1:0] ain;
        logic [SIZE_W:0]     sh;
        logic                ge;
        for (int s = 0; s < INDEX_W; s++)
        begin
            if (s == 0)
            begin
                vin = valid;
                nin = index;
                rin = '0;
                ain = acc;
            end
            else
            begin
                vin = v_reg[s-1];
                nin = num_reg[s-1];
                rin = rem_reg[s-1];
                ain = acc_reg[s-1];
            end
            sh = {rin, nin[INDEX_W-1]};
            ge = (sh >= {1'b0, divisor});
            v_next[s]   = vin;
            num_next[s] = {nin[INDEX_W-2:0], ge};
            rem_next[s] = ge ? SIZE_W'(sh - {1'b0, divisor}) : sh[SIZE_W-1:0];
            acc_next[s] = ain;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < INDEX_W; s++)
            begin
                v_reg[s] <= 1'b0;
            end
            mul_valid_reg <= 1'b0;
            sum_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            for (int s = 0; s < INDEX_W; s++)
            begin
                v_reg[s] <= v_next[s];
            end
            mul_valid_reg <= v_reg[INDEX_W-1];
            sum_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < INDEX_W; s++)
            begin
                num_reg[s] <= num_next[s];
                rem_reg[s] <= rem_next[s];
                acc_reg[s] <= acc_next[s];
            end
            mul_quot_reg <= num_reg[INDEX_W-1];
            mul_prod_reg <= rem_reg[INDEX_W-1] * step;
            mul_acc_reg  <= acc_reg[INDEX_W-1];
            sum_quot_reg <= mul_quot_reg;
            sum_acc_reg  <= mul_acc_reg + OFFSET_W'(mul_prod_reg);
        end
    end

    assign quot_valid = sum_valid_reg;
    assign quot       = sum_quot_reg;
    assign quot_acc   = sum_acc_reg;

endmodule

FILE: hdl/strided_tensor_offset.sv
// ---------------------------------------------------------------------------
// Strided tensor offset generator
// Turns a row-major linear element index into a strided memory offset.
// ---------------------------------------------------------------------------
// Requests arrive on linear_index with index_valid and leave on
// element_offset with offset_valid; each side is held off by its stall.
// Sizes and strides are written through the cfg port (cfg_ready is always
// high); the user must write them only while no request is in flight, and
// the block does not enforce it. Index 0 to 3 are the sizes from the
// outermost dimension in, 4 to 7 the strides, higher indexes are ignored.
// Each used dimension is a 34-stage section: 32 divider stages giving one
// quotient bit each, one stride multiply stage and one accumulate stage.
// One request is accepted every cycle while the output is not stalled.
// A stalled result holds the whole pipeline, so index_stall follows
// offset_stall whenever a result is waiting, and nothing is lost.
// Reset empties the pipeline and sets every size to 1 and every stride
// to 0.
// ---------------------------------------------------------------------------
`include "strided_tensor_offset_assert.svh"

module strided_tensor_offset
    import sto_pkg::*;
#(
    parameter int MAX_RANK = DEF_MAX_RANK
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   index_valid,
    output logic                   index_stall,
    input  logic [INDEX_W-1:0]     linear_index,
    output logic                   offset_valid,
    input  logic                   offset_stall,
    output logic [OFFSET_W-1:0]    element_offset,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int NDIM = (MAX_RANK < REG_DIMS) ? MAX_RANK : REG_DIMS;

    logic [SIZE_W-1:0]   size_reg [0:REG_DIMS-1];
    logic [STEP_W-1:0]   step_reg [0:REG_DIMS-1];

    logic                en;
    logic                ch_valid [0:NDIM];
    logic [INDEX_W-1:0]  ch_index [0:NDIM];
    logic [OFFSET_W-1:0] ch_acc   [0:NDIM];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < REG_DIMS; d++)
            begin
                size_reg[d] <= SIZE_W'(1);
                step_reg[d] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index < REG_STEP_OUTER)
            begin
                size_reg[cfg_index[1:0]] <= cfg_data[SIZE_W-1:0];
            end
            else if (cfg_index <= REG_STEP_INNER)
            begin
                step_reg[cfg_index[1:0]] <= cfg_data[STEP_W-1:0];
            end
        end
    end

    assign en          = !(offset_valid && offset_stall);
    assign index_stall = !en;

    assign ch_valid[0] = index_valid;
    assign ch_index[0] = linear_index;
    assign ch_acc[0]   = '0;

    for (genvar k = 0; k < NDIM; k++)
    begin : g_dim
        sto_dim u_dim (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en),
            .size       (size_reg[REG_DIMS-1-k]),
            .step       (step_reg[REG_DIMS-1-k]),
            .valid      (ch_valid[k]),
            .index      (ch_index[k]),
            .acc        (ch_acc[k]),
            .quot_valid (ch_valid[k+1]),
            .quot       (ch_index[k+1]),
            .quot_acc   (ch_acc[k+1])
        );
    end

    assign offset_valid   = ch_valid[NDIM];
    assign element_offset = ch_acc[NDIM];

    `STO_ASSERT_SAME(a_stall_back, clk, rst_n, offset_valid && offset_stall, index_stall)
    `STO_ASSERT_NEXT(a_cfg_inner, clk, rst_n, cfg_valid && cfg_index == REG_SIZE_INNER, size_reg[REG_DIMS-1] == $past(cfg_data[SIZE_W-1:0]))
    `STO_ASSERT_NEXT(a_hold, clk, rst_n, offset_valid && offset_stall, offset_valid && $stable(element_offset))

endmodule

FILE: test/strided_tensor_offset_tb.sv
// ---------------------------------------------------------------------------
// Strided tensor offset generator testbench
// Drives linear index requests under random idling and stalls, predicts each
// offset from the programmed sizes and strides, and checks results in order.
// ---------------------------------------------------------------------------
module strided_tensor_offset_tb;
    import sto_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 200;

    logic clk;
    logic rst_n;
    logic index_valid;
    logic index_stall;
    logic [INDEX_W-1:0] linear_index;
    logic offset_valid;
    logic offset_stall;
    logic [OFFSET_W-1:0] element_offset;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic [INDEX_W-1:0] pending_indexes[$];
    logic [OFFSET_W-1:0] expected_offsets[$];
    logic [SIZE_W-1:0] dim_size[REG_DIMS];
    logic [STEP_W-1:0] dim_step[REG_DIMS];
    int failures = 0;
    int idle_cycles = 0;
    bit calm;
    logic index_stall_q;

    strided_tensor_offset DUT (
        .clk(clk), .rst_n(rst_n),
        .index_valid(index_valid), .index_stall(index_stall),
        .linear_index(linear_index),
        .offset_valid(offset_valid), .offset_stall(offset_stall),
        .element_offset(element_offset),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic logic [OFFSET_W-1:0] tensor_offset(logic [INDEX_W-1:0] idx);
        logic [63:0] remaining;
        logic [63:0] size;
        logic [63:0] sum;
        sum = '0;
        remaining = 64'(idx);
        for (int d = REG_DIMS - 1; d >= 0; d--)
        begin
            size = (dim_size[d] == 0) ? 64'd1 : 64'(dim_size[d]);
            sum += (remaining % size) * 64'(dim_step[d]);
            remaining = remaining / size;
        end
        return sum[OFFSET_W-1:0];
    endfunction

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
        logic [CFG_INDEX_W-1:0] raw;
        raw = idx;
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx < REG_STEP_OUTER)
            dim_size[raw[1:0]] = value[SIZE_W-1:0];
        else
            dim_step[raw[1:0]] = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_shape(logic [15:0] s0, logic [15:0] s1, logic [15:0] s2,
                             logic [15:0] s3, logic [31:0] t0, logic [31:0] t1,
                             logic [31:0] t2, logic [31:0] t3);
        while (pending_indexes.size() != 0 || expected_offsets.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        write_reg(REG_SIZE_OUTER, 32'(s0));
        write_reg(REG_SIZE_SECOND, 32'(s1));
        write_reg(REG_SIZE_THIRD, 32'(s2));
        write_reg(REG_SIZE_INNER, 32'(s3));
        write_reg(REG_STEP_OUTER, t0);
        write_reg(REG_STEP_SECOND, t1);
        write_reg(REG_STEP_THIRD, t2);
        write_reg(REG_STEP_INNER, t3);
    endtask

    task automatic push_random(int count);
        for (int i = 0; i < count; i++)
            pending_indexes.push_back($urandom);
    endtask

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_valid <= 1'b0;
            linear_index <= '0;
            offset_stall <= 1'b0;
        end
        else
        begin
            offset_stall <= !calm && ($urandom_range(99) < 18);
            if (!index_valid || !index_stall_q)
            begin
                if (pending_indexes.size() != 0 && (calm || $urandom_range(99) >= 18))
                begin
                    index_valid <= 1'b1;
                    linear_index <= pending_indexes.pop_front();
                end
                else
                    index_valid <= 1'b0;
            end
        end
    end

    // Stall as sampled at the last rising edge decides whether the request moved.
    always @(posedge clk)
        index_stall_q <= index_stall;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((index_valid && !index_stall) || (offset_valid && !offset_stall)
                || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (index_valid && !index_stall)
                expected_offsets.push_back(tensor_offset(linear_index));
            if (offset_valid && !offset_stall)
            begin
                if (expected_offsets.size() == 0)
                begin
                    $display("%0t: unexpected offset %h", $time, element_offset);
                    failures <= failures + 1;
                end
                else if (expected_offsets[0] !== element_offset)
                begin
                    $display("%0t: offset mismatch expected %h actual %h",
                             $time, expected_offsets[0], element_offset);
                    failures <= failures + 1;
                    void'(expected_offsets.pop_front());
                end
                else
                    void'(expected_offsets.pop_front());
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        calm = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_SIZE_OUTER;
        cfg_data = '0;
        for (int d = 0; d < REG_DIMS; d++)
        begin
            dim_size[d] = 1;
            dim_step[d] = 0;
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        pending_indexes.push_back(32'd0);
        pending_indexes.push_back(32'hFFFF_FFFF);
        set_shape(16'd3, 16'd5, 16'd7, 16'd11, 32'd385, 32'd77, 32'd11, 32'd1);
        pending_indexes.push_back(32'd0);
        pending_indexes.push_back(32'd1154);
        pending_indexes.push_back(32'd1155);
        pending_indexes.push_back(32'hFFFF_FFFF);
        pending_indexes.push_back(32'h8000_0000);
        set_shape(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        pending_indexes.push_back(32'hFFFF_FFFF);
        pending_indexes.push_back(32'hFFFE_FFFF);
        pending_indexes.push_back(32'h0001_0000);
        pending_indexes.push_back(32'h0);
        // Zero sizes act as size one.
        set_shape(16'd0, 16'd0, 16'd4, 16'd0, 32'd9, 32'd8, 32'd100, 32'd3);
        pending_indexes.push_back(32'd7);
        pending_indexes.push_back(32'hFFFF_FFFF);
        pending_indexes.push_back(32'h5555_5555);
        pending_indexes.push_back(32'hAAAA_AAAA);

        for (int phase = 0; phase < 6; phase++)
        begin
            set_shape(16'($urandom), 16'($urandom_range(1, 64)),
                      16'($urandom_range(0, 300)), 16'($urandom),
                      $urandom, $urandom, $urandom, $urandom);
            calm = (phase == 3);
            push_random(110);
        end
        calm = 1'b0;
        set_shape(16'd1, 16'd1, 16'd1, 16'd1, 32'd0, 32'd0, 32'd0, 32'd0);
        push_random(40);

        while (pending_indexes.size() != 0 || expected_offsets.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0 && expected_offsets.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
